>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the RTL
// Clocked property wrappers, disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication in the same cycle.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Implication in the following cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> rtl/core/cetd_pkg.sv
// ----------------------------------------------------------------------------
// cetd_pkg
// Field widths and calendar constants for the epoch to civil date converter.
// ----------------------------------------------------------------------------
package cetd_pkg;

    localparam int EPOCH_W  = 32;
    localparam int YEAR_W   = 12;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int SECOND_W = 6;

    // 86400 = 128 * 675: the low 7 bits of the count bypass the divider.
    localparam int DAY_SHIFT       = 7;
    localparam int SECS_DAY_ODD    = 675;
    localparam int REM_W           = 17;

    localparam int DAYS_PER_ERA    = 146097;
    localparam int DAYS_TO_1970    = 719468;   // 0000-03-01 to 1970-01-01
    localparam int DAYS_PER_4Y     = 1460;
    localparam int DAYS_PER_100Y   = 36524;
    localparam int LAST_DAY_OF_ERA = 146096;
    localparam int DAYS_PER_YEAR   = 365;
    localparam int YEARS_PER_CENT  = 100;
    localparam int YEARS_PER_ERA   = 400;
    localparam int DAYS_PER_5MON   = 153;
    localparam int MONTHS_PER_5MON = 5;
    localparam int SECS_PER_HOUR   = 3600;
    localparam int SECS_PER_MIN    = 60;

    localparam int DOE_W = 18;
    localparam int YOE_W = 10;
    localparam int DOY_W = 9;
    localparam int MP_W  = 4;
    localparam int MDX_W = 11;   // width of 5*doy+2 and 153*mp+2

    localparam logic [MP_W-1:0]    MP_JANUARY = MP_W'(10);
    localparam logic [MONTH_W-1:0] MONTH_FEB  = MONTH_W'(2);

endpackage

>>> rtl/core/cetd_epoch_if.sv
// ----------------------------------------------------------------------------
// cetd_epoch_if
// Request channel carrying one epoch second count.
// ----------------------------------------------------------------------------
interface cetd_epoch_if;
    import cetd_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [EPOCH_W-1:0]   epoch_seconds;

    modport source (output valid, output epoch_seconds, input ready);
    modport sink   (input valid, input epoch_seconds, output ready);
endinterface

>>> rtl/core/cetd_civil_if.sv
// ----------------------------------------------------------------------------
// cetd_civil_if
// Request channel carrying one civil date and time of day.
// ----------------------------------------------------------------------------
interface cetd_civil_if;
    import cetd_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [YEAR_W-1:0]    year_out;
    logic [MONTH_W-1:0]   month_out;
    logic [DAY_W-1:0]     day_out;
    logic [HOUR_W-1:0]    hour_out;
    logic [MINUTE_W-1:0]  minute_out;
    logic [SECOND_W-1:0]  second_out;

    modport source (output valid, output year_out, output month_out, output day_out,
                    output hour_out, output minute_out, output second_out, input ready);
    modport sink   (input valid, input year_out, input month_out, input day_out,
                    input hour_out, input minute_out, input second_out, output ready);
endinterface

>>> rtl/core/epoch_seconds_to_civil_date.sv
// ----------------------------------------------------------------------------
// epoch_seconds_to_civil_date
// Unix second count to Gregorian year, month, day, hour, minute, second.
// ----------------------------------------------------------------------------
// Usage:
//   epoch (sink): one request holds an unsigned 32-bit count of seconds since
//   1970-01-01 00:00:00. civil (source): one request per input holds the
//   date and time of day, in input order. Both use valid/ready; a request
//   moves on a rising clk edge with valid and ready high.
// Pipeline: 32 register stages from the epoch port to the civil port.
// Throughput: one request per cycle when civil is not stalled. Ten constant
//   dividers of three stages each (reciprocal multiply, back multiply, fixup)
//   plus two glue stages form the pipeline; all stages advance together.
// Stall: while civil.valid is high and civil.ready low the whole pipeline
//   holds and epoch.ready is low; nothing is dropped or repeated.
// Reset: rst_n (async, low) clears all valid bits; the pipeline is empty.
// EPOCH_BITS (32..40) sets the internal count width; the port stays 32 bits.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module epoch_seconds_to_civil_date #(
    parameter int EPOCH_BITS = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    cetd_epoch_if.sink   epoch,
    cetd_civil_if.source civil
);
    import cetd_pkg::*;

    localparam int EB    = EPOCH_BITS;
    localparam int W1    = EB - DAY_SHIFT;
    localparam int DAYS_W = EB - 16;
    localparam int W2    = EB - 11;
    localparam int ERA_W = EB - 28;

    typedef struct packed {
        logic [ERA_W-1:0] era;
        logic [DOE_W-1:0] doe;
        logic [REM_W-1:0] rem;
    } tag3_t;

    typedef struct packed {
        tag3_t      t3;
        logic [7:0] a;
    } tag4_t;

    typedef struct packed {
        tag3_t            t3;
        logic [YOE_W-1:0] yoe;
    } tag6_t;

    typedef struct packed {
        logic [ERA_W-1:0] era;
        logic [YOE_W-1:0] yoe;
        logic [REM_W-1:0] rem;
        logic [DOY_W-1:0] doy;
    } tag7_t;

    typedef struct packed {
        tag7_t           t7;
        logic [MP_W-1:0] mp;
    } tag8_t;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } date_t;

    typedef struct packed {
        date_t             d;
        logic [HOUR_W-1:0] hour;
    } tag10_t;

    logic en;
    logic [EB-1:0] t;

    // global advance: everything moves unless the head result is blocked
    assign en          = !civil.valid || civil.ready;
    assign epoch.ready = en;
    assign t           = EB'(epoch.epoch_seconds);

    // days and seconds of day
    logic                 v1;
    logic [DAYS_W-1:0]    days;
    logic [9:0]           r1;
    logic [DAY_SHIFT-1:0] low7;
    logic [REM_W-1:0]     rem1;

    cetd_divc #(.W(W1), .D(SECS_DAY_ODD), .TW(DAY_SHIFT)) u_day (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(epoch.valid),
        .x(t[EB-1:DAY_SHIFT]), .tag_in(t[DAY_SHIFT-1:0]),
        .out_valid(v1), .q(days), .r(r1), .tag_out(low7)
    );
    assign rem1 = {r1, low7};

    // era and day of era
    logic              v2;
    logic [W2-1:0]     z;
    logic [ERA_W-1:0]  era2;
    logic [DOE_W-1:0]  doe2;
    logic [REM_W-1:0]  rem2;

    assign z = W2'(days) + W2'(DAYS_TO_1970);

    cetd_divc #(.W(W2), .D(DAYS_PER_ERA), .TW(REM_W)) u_era (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v1),
        .x(z), .tag_in(rem1),
        .out_valid(v2), .q(era2), .r(doe2), .tag_out(rem2)
    );

    tag3_t tag3_in, tag3_out;
    tag4_t tag4_in, tag4_out;
    logic       v3, v4;
    logic [7:0] a3;
    logic [2:0] b4;

    assign tag3_in = '{era: era2, doe: doe2, rem: rem2};

    cetd_divc #(.W(DOE_W), .D(DAYS_PER_4Y), .TW($bits(tag3_t))) u_d4y (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v2),
        .x(doe2), .tag_in(tag3_in),
        .out_valid(v3), .q(a3), .r(), .tag_out(tag3_out)
    );

    assign tag4_in = '{t3: tag3_out, a: a3};

    cetd_divc #(.W(DOE_W), .D(DAYS_PER_100Y), .TW($bits(tag4_t))) u_d100y (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v3),
        .x(tag3_out.doe), .tag_in(tag4_in),
        .out_valid(v4), .q(b4), .r(), .tag_out(tag4_out)
    );

    // year of era
    logic [DOE_W-1:0] n;
    logic             v5, v6;
    logic [YOE_W-1:0] yoe5;
    tag3_t            tag5_out;
    tag6_t            tag6_in, tag6_out;
    logic [3:0]       c6;

    assign n = tag4_out.t3.doe - DOE_W'(tag4_out.a) + DOE_W'(b4)
             - DOE_W'(tag4_out.t3.doe == DOE_W'(LAST_DAY_OF_ERA));

    cetd_divc #(.W(DOE_W), .D(DAYS_PER_YEAR), .TW($bits(tag3_t))) u_yoe (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v4),
        .x(n), .tag_in(tag4_out.t3),
        .out_valid(v5), .q(yoe5), .r(), .tag_out(tag5_out)
    );

    assign tag6_in = '{t3: tag5_out, yoe: yoe5};

    cetd_divc #(.W(YOE_W), .D(YEARS_PER_CENT), .TW($bits(tag6_t))) u_cent (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v5),
        .x(yoe5), .tag_in(tag6_in),
        .out_valid(v6), .q(c6), .r(), .tag_out(tag6_out)
    );

    // day of year, registered
    logic [DOE_W-1:0] yday;
    logic             v7_reg;
    tag7_t            tag7_reg, tag7_next;

    assign yday = DOE_W'(tag6_out.yoe) * DOE_W'(DAYS_PER_YEAR)
                + DOE_W'(tag6_out.yoe >> 2) - DOE_W'(c6);

    always_comb
    begin
        tag7_next.era = tag6_out.t3.era;
        tag7_next.yoe = tag6_out.yoe;
        tag7_next.rem = tag6_out.t3.rem;
        tag7_next.doy = DOY_W'(tag6_out.t3.doe - yday);
    end

    // month index from March
    logic             v8, v9;
    logic [MDX_W-1:0] x7, x8;
    logic [MP_W-1:0]  mp8;
    logic [8:0]       k9;
    tag7_t            tag8_t7;
    tag8_t            tag8_in, tag8_out;

    assign x7 = MDX_W'(tag7_reg.doy) * MDX_W'(MONTHS_PER_5MON) + MDX_W'(2);

    cetd_divc #(.W(MDX_W), .D(DAYS_PER_5MON), .TW($bits(tag7_t))) u_mp (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v7_reg),
        .x(x7), .tag_in(tag7_reg),
        .out_valid(v8), .q(mp8), .r(), .tag_out(tag8_t7)
    );

    assign x8      = MDX_W'(mp8) * MDX_W'(DAYS_PER_5MON) + MDX_W'(2);
    assign tag8_in = '{t7: tag8_t7, mp: mp8};

    cetd_divc #(.W(MDX_W), .D(MONTHS_PER_5MON), .TW($bits(tag8_t))) u_mstart (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v8),
        .x(x8), .tag_in(tag8_in),
        .out_valid(v9), .q(k9), .r(), .tag_out(tag8_out)
    );

    // civil date, registered
    logic               v10_reg;
    date_t              date_reg, date_next;
    logic [REM_W-1:0]   rem10_reg;
    logic [MONTH_W-1:0] month;

    always_comb
    begin
        month = (tag8_out.mp < MP_JANUARY) ? MONTH_W'(tag8_out.mp + MP_W'(3))
                                           : MONTH_W'(tag8_out.mp - MP_W'(9));
        date_next.month = month;
        date_next.day   = DAY_W'(tag8_out.t7.doy - k9 + DOY_W'(1));
        date_next.year  = YEAR_W'(tag8_out.t7.yoe)
                        + YEAR_W'(tag8_out.t7.era) * YEAR_W'(YEARS_PER_ERA)
                        + YEAR_W'(month <= MONTH_FEB);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v7_reg  <= 1'b0;
            v10_reg <= 1'b0;
        end
        else if (en)
        begin
            v7_reg  <= v6;
            v10_reg <= v9;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tag7_reg  <= tag7_next;
            date_reg  <= date_next;
            rem10_reg <= tag8_out.t7.rem;
        end
    end

    // time of day
    logic              v11, v12;
    logic [5:0]        hour11;
    logic [11:0]       r11;
    date_t             date11;
    tag10_t            tag12_in, tag12_out;
    logic [6:0]        min12;
    logic [5:0]        sec12;

    cetd_divc #(.W(REM_W), .D(SECS_PER_HOUR), .TW($bits(date_t))) u_hour (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v10_reg),
        .x(rem10_reg), .tag_in(date_reg),
        .out_valid(v11), .q(hour11), .r(r11), .tag_out(date11)
    );

    assign tag12_in = '{d: date11, hour: HOUR_W'(hour11)};

    cetd_divc #(.W(12), .D(SECS_PER_MIN), .TW($bits(tag10_t))) u_min (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v11),
        .x(r11), .tag_in(tag12_in),
        .out_valid(v12), .q(min12), .r(sec12), .tag_out(tag12_out)
    );

    assign civil.valid      = v12;
    assign civil.year_out   = tag12_out.d.year;
    assign civil.month_out  = tag12_out.d.month;
    assign civil.day_out    = tag12_out.d.day;
    assign civil.hour_out   = tag12_out.hour;
    assign civil.minute_out = MINUTE_W'(min12);
    assign civil.second_out = sec12;

    // a blocked result freezes the input side
    `ASSERT_SAME(a_stall_blocks_input, clk, rst_n,
        civil.valid && !civil.ready, !epoch.ready)
    `ASSERT_SAME(a_date_range, clk, rst_n, civil.valid,
        civil.month_out >= MONTH_W'(1) && civil.month_out <= MONTH_W'(12)
        && civil.day_out >= DAY_W'(1))
    `ASSERT_SAME(a_time_range, clk, rst_n, civil.valid,
        civil.hour_out < HOUR_W'(24) && civil.minute_out < MINUTE_W'(60)
        && civil.second_out < SECOND_W'(60))
    `ASSERT_NEXT(a_stall_holds_head, clk, rst_n,
        civil.valid && !civil.ready, civil.valid && $stable(civil.year_out))
endmodule

>>> rtl/core/cetd_divc.sv
// ----------------------------------------------------------------------------
// cetd_divc
// Three stage divide by a constant: reciprocal multiply, back multiply, fixup.
// ----------------------------------------------------------------------------
module cetd_divc #(
    parameter int W  = 18,
    parameter int D  = 3,
    parameter int TW = 1,
    localparam int DW = $clog2(D + 1),
    localparam int QW = W - DW + 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [W-1:0]  x,
    input  logic [TW-1:0] tag_in,
    output logic          out_valid,
    output logic [QW-1:0] q,
    output logic [DW-1:0] r,
    output logic [TW-1:0] tag_out
);
    import cetd_pkg::*;

    localparam logic [W:0]    ONE_W  = {1'b1, {W{1'b0}}};
    localparam logic [W:0]    M_FULL = ONE_W / (W + 1)'(D);
    localparam logic [QW-1:0] M      = M_FULL[QW-1:0];
    localparam logic [DW-1:0] DC     = DW'(D);

    logic [2:0]        v_reg;
    logic [W-1:0]      x1_reg;
    logic [QW-1:0]     q1_reg, q2_reg, q3_reg;
    logic [DW:0]       r2_reg;
    logic [DW-1:0]     r3_reg;
    logic [TW-1:0]     t1_reg, t2_reg, t3_reg;

    logic [W+QW-1:0]   prod;
    logic [QW+DW-1:0]  back;
    logic [W:0]        diff;
    logic              ge;
    logic [QW-1:0]     q1_next;
    logic [DW:0]       r2_next;

    // q1 is floor(x/D) or one less
    assign prod    = {{QW{1'b0}}, x} * {{W{1'b0}}, M};
    assign q1_next = prod[W+QW-1:W];
    assign back    = {{DW{1'b0}}, q1_reg} * {{QW{1'b0}}, DC};
    assign diff    = {1'b0, x1_reg} - back;
    assign r2_next = diff[DW:0];
    assign ge      = (r2_reg >= {1'b0, DC});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1_reg <= x;
            q1_reg <= q1_next;
            t1_reg <= tag_in;
            q2_reg <= q1_reg;
            r2_reg <= r2_next;
            t2_reg <= t1_reg;
            q3_reg <= ge ? q2_reg + QW'(1) : q2_reg;
            r3_reg <= ge ? DW'(r2_reg - {1'b0, DC}) : r2_reg[DW-1:0];
            t3_reg <= t2_reg;
        end
    end

    assign out_valid = v_reg[2];
    assign q         = q3_reg;
    assign r         = r3_reg;
    assign tag_out   = t3_reg;
endmodule
